FILE: rtl/core/bcpg_pkg.sv
// ----------------------------------------------------------------------------
// bcpg_pkg
// Shared types and constants of the Bezier curve point generator.
// ----------------------------------------------------------------------------
package bcpg_pkg;

  localparam int unsigned CoordW    = 16;
  localparam int unsigned WeightW   = 48;
  localparam int unsigned HalfW     = 24;
  localparam int unsigned SumW      = 64;
  localparam int unsigned IdxW      = 6;
  localparam int unsigned CountW    = 7;
  localparam int unsigned ResultMax = 64;

  typedef logic [CoordW-1:0]  coord_t;
  typedef logic [WeightW-1:0] weight_t;

  typedef struct packed {
    logic            vld;
    logic [IdxW-1:0] idx;
    logic            last;
    logic            endp;
  } tag_t;

endpackage

FILE: rtl/core/bezier_curve_point_generator.sv
// ----------------------------------------------------------------------------
// bezier_curve_point_generator
// Emits evenly spaced samples of a quadratic or cubic Bezier curve.
// ----------------------------------------------------------------------------
// A transaction first sets up the step size of t (a bit-serial division of
// 2^17 by twice the interval count), then one sample issues per cycle into a
// seven-stage pipeline; busy_o stays high until the last sample of a request
// has been strobed. Samples appear on consecutive cycles and cannot be stalled.
module bezier_curve_point_generator #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  output logic         busy_o,
  input  logic         action_i,
  input  logic [15:0]  start_x_i,
  input  logic [15:0]  start_y_i,
  input  logic [15:0]  ctrl1_x_i,
  input  logic [15:0]  ctrl1_y_i,
  input  logic [15:0]  ctrl2_x_i,
  input  logic [15:0]  ctrl2_y_i,
  input  logic [15:0]  end_x_i,
  input  logic [15:0]  end_y_i,
  input  logic [6:0]   point_count_i,
  output logic         valid_o,
  output logic [15:0]  out_x_o,
  output logic [15:0]  out_y_o,
  output logic [5:0]   sample_index_o,
  output logic         last_o
);

  localparam int unsigned Limit = (MAX_POINTS < bcpg_pkg::ResultMax) ?
                                  MAX_POINTS : bcpg_pkg::ResultMax;
  localparam logic [6:0] LimitC = 7'(Limit);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_ISSUE = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  localparam logic [15:0] Bias = 16'h8000;

  logic [1:0]  state_q, state_d;
  logic        cubic_q;
  bcpg_pkg::coord_t [3:0] bx_q, by_q;
  logic [5:0]  d_q;
  logic [6:0]  d2_q;
  logic [4:0]  cnt_q;
  logic [6:0]  rem_q;
  logic [16:0] quo_q;
  logic [16:0] t_q;
  logic [7:0]  r_q;
  logic [5:0]  idx_q;
  logic [6:0]  n_d;
  logic [7:0]  rem2;
  logic        ge;
  logic [7:0]  rsum;
  logic        accept;

  // issue stage and pipeline
  bcpg_pkg::tag_t tag1_q;
  logic [15:0] t1_q, u1_q, t2_q, u2_q;
  logic [31:0] uu_q, tt_q, ut_q;
  bcpg_pkg::tag_t tag_q [5];
  bcpg_pkg::weight_t [3:0] w_q;
  bcpg_pkg::coord_t lx, ly;
  logic        out_vld_q;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    n_d = point_count_i;
    if (n_d < (action_i ? 7'd4 : 7'd3)) n_d = action_i ? 7'd4 : 7'd3;
    if (n_d > LimitC) n_d = LimitC;
  end

  assign rem2 = {rem_q, (cnt_q == 5'd0)};
  assign ge   = (rem2 >= {1'b0, d2_q});
  assign rsum = r_q + {1'b0, rem_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_DIV;
      ST_DIV:   if (cnt_q == 5'd17) state_d = ST_ISSUE;
      ST_ISSUE: if (idx_q == d_q) state_d = ST_DRAIN;
      ST_DRAIN: if (out_vld_q && last_o) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      tag1_q    <= '0;
      for (int k = 0; k < 5; k++) tag_q[k] <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tag1_q.vld  <= (state_q == ST_ISSUE);
      tag1_q.idx  <= idx_q;
      tag1_q.last <= (idx_q == d_q);
      tag1_q.endp <= (idx_q == 6'd0) || (idx_q == d_q);
      tag_q[0] <= tag1_q;
      for (int k = 1; k < 5; k++) tag_q[k] <= tag_q[k-1];
      out_vld_q <= tag_q[4].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cubic_q <= action_i;
      bx_q <= {end_x_i ^ Bias, ctrl2_x_i ^ Bias, ctrl1_x_i ^ Bias, start_x_i ^ Bias};
      by_q <= {end_y_i ^ Bias, ctrl2_y_i ^ Bias, ctrl1_y_i ^ Bias, start_y_i ^ Bias};
      d_q   <= 6'(n_d - 7'd1);
      d2_q  <= 7'((n_d - 7'd1) << 1);
      cnt_q <= '0;
      rem_q <= '0;
      quo_q <= '0;
    end
    if (state_q == ST_DIV) begin
      cnt_q <= cnt_q + 5'd1;
      rem_q <= ge ? 7'(rem2 - {1'b0, d2_q}) : rem2[6:0];
      quo_q <= {quo_q[15:0], ge};
      t_q   <= '0;
      r_q   <= {2'b00, d_q};
      idx_q <= '0;
    end
    if (state_q == ST_ISSUE) begin
      idx_q <= idx_q + 6'd1;
      if (rsum >= {1'b0, d2_q}) begin
        r_q <= rsum - {1'b0, d2_q};
        t_q <= t_q + quo_q + 17'd1;
      end else begin
        r_q <= rsum;
        t_q <= t_q + quo_q;
      end
    end
    // stage 1: t and u
    t1_q <= t_q[15:0];
    u1_q <= 16'(17'h10000 - t_q);
    // stage 2: pairwise products
    uu_q <= u1_q * u1_q;
    tt_q <= t1_q * t1_q;
    ut_q <= u1_q * t1_q;
    t2_q <= t1_q;
    u2_q <= u1_q;
    // stage 3: Bernstein weights, scaled to 2^48
    if (cubic_q) begin
      w_q[0] <= uu_q * u2_q;
      w_q[1] <= 48'((uu_q * t2_q) * 50'd3);
      w_q[2] <= 48'((tt_q * u2_q) * 50'd3);
      w_q[3] <= tt_q * t2_q;
    end else begin
      w_q[0] <= {uu_q, 16'h0000};
      w_q[1] <= {ut_q[30:0], 17'h00000};
      w_q[2] <= '0;
      w_q[3] <= {tt_q, 16'h0000};
    end
    // output stage
    out_x_o <= tag_q[4].endp ? ((tag_q[4].last ? bx_q[3] : bx_q[0]) ^ Bias) : lx;
    out_y_o <= tag_q[4].endp ? ((tag_q[4].last ? by_q[3] : by_q[0]) ^ Bias) : ly;
    sample_index_o <= tag_q[4].idx;
    last_o <= tag_q[4].last;
  end

  assign valid_o = out_vld_q;

  bcpg_lane u_lane_x (
    .clk_i (clk_i),
    .w_i   (w_q),
    .p_i   (bx_q),
    .res_o (lx)
  );

  bcpg_lane u_lane_y (
    .clk_i (clk_i),
    .w_i   (w_q),
    .p_i   (by_q),
    .res_o (ly)
  );

endmodule

FILE: rtl/core/bcpg_lane.sv
// ----------------------------------------------------------------------------
// bcpg_lane
// Three-stage weighted sum of four offset-binary coordinates, rounded to Q8.8.
// ----------------------------------------------------------------------------
module bcpg_lane (
  input  logic                         clk_i,
  input  bcpg_pkg::weight_t [3:0]      w_i,
  input  bcpg_pkg::coord_t  [3:0]      p_i,
  output bcpg_pkg::coord_t             res_o
);

  localparam int unsigned PpW = bcpg_pkg::HalfW + bcpg_pkg::CoordW;

  logic [PpW-1:0]                lo_q [4];
  logic [PpW-1:0]                hi_q [4];
  logic [bcpg_pkg::SumW-1:0]     prod_q [4];
  bcpg_pkg::coord_t              res_q;
  logic [bcpg_pkg::SumW-1:0]     sum_d;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      lo_q[k] <= w_i[k][bcpg_pkg::HalfW-1:0] * p_i[k];
      hi_q[k] <= w_i[k][bcpg_pkg::WeightW-1:bcpg_pkg::HalfW] * p_i[k];
      prod_q[k] <= ({{(bcpg_pkg::SumW-PpW){1'b0}}, hi_q[k]} << bcpg_pkg::HalfW)
                 + {{(bcpg_pkg::SumW-PpW){1'b0}}, lo_q[k]};
    end
    res_q <= sum_d[bcpg_pkg::SumW-1:bcpg_pkg::WeightW];
  end

  assign sum_d = prod_q[0] + prod_q[1] + prod_q[2] + prod_q[3]
               + (64'd1 << (bcpg_pkg::WeightW - 1));

  // back from offset binary to two's complement
  assign res_o = res_q ^ {1'b1, {(bcpg_pkg::CoordW-1){1'b0}}};

endmodule

FILE: rtl/core/bcpg_checker.sv
// ----------------------------------------------------------------------------
// bcpg_checker
// Port-level checks of the Bezier curve point generator.
// ----------------------------------------------------------------------------
module bcpg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       valid_o,
  input logic [5:0] sample_index_o,
  input logic       last_o
);

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o) else $error("sample outside a transaction");

  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("start not taken");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |=> !busy_o) else $error("busy after last sample");

  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |=> valid_o && (sample_index_o == $past(sample_index_o) + 6'd1))
    else $error("sample sequence broken");

  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_o) |-> sample_index_o == 6'd0) else $error("first index not zero");

endmodule

bind bezier_curve_point_generator bcpg_checker u_bcpg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .valid_o        (valid_o),
  .sample_index_o (sample_index_o),
  .last_o         (last_o)
);
